>>> rtl/brb_pkg.sv
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types and codes for the byte ring buffer with peek and consume.
// ----------------------------------------------------------------------------
package brb_pkg;

  // Field widths fixed by the word formats
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 12;
  localparam int unsigned ST_W   = 2;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PEEK    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CONSUME = 2'd2;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_NO_ROOM = 2'd1;
  localparam logic [ST_W-1:0] ST_OVER    = 2'd2;

  // Input word
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  length;
    logic              last_byte;
  } in_t;

  // Result word
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic [LEN_W-1:0]  count;
    logic [ST_W-1:0]   status;
    logic [LEN_W-1:0]  free_space;
    logic              last_result;
  } out_t;

endpackage

>>> rtl/brb_stream_if.sv
// ----------------------------------------------------------------------------
// brb_stream_if
// Valid/ready channel carrying one payload word per handshake.
// ----------------------------------------------------------------------------
interface brb_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

>>> rtl/brb_mem.sv
// ----------------------------------------------------------------------------
// brb_mem
// Byte store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module brb_mem #(
  parameter int unsigned ADDR_BITS = 12
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [ADDR_BITS-1:0] wr_addr_i,
  input  logic [7:0]           wr_data_i,
  input  logic                 rd_en_i,
  input  logic [ADDR_BITS-1:0] rd_addr_i,
  output logic [7:0]           rd_data_o
);

  localparam int unsigned DEPTH = 1 << ADDR_BITS;

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/byte_ring_buffer_peek_consume.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer_peek_consume
// Circular byte buffer with burst writes, peek reads and consume.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one command word per handshake: a write byte of a burst,
//   a peek, or a consume. out_o returns result words through a one-word
//   output register; a new command is taken in the cycle the waiting result
//   word is taken.
//   Only the last byte of a burst produces a result, in the cycle after
//   acceptance. A consume gives one result in the next cycle. A peek of n
//   bytes starts a read of the byte store on acceptance and then, while
//   out_o takes each word, emits one byte per cycle, set by the single read
//   port of the store; in all n result words, while in_i is held off. An
//   empty peek gives one result word in the next cycle.
//   When out_o stalls, the output register holds its word and in_i is held
//   off until the word is taken; a running peek pauses on the same byte.
//   Reset empties the buffer (pointers, held count and burst state to zero)
//   and drops any pending result. The store itself is not cleared; only
//   held bytes are ever read, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module byte_ring_buffer_peek_consume #(
  parameter int unsigned ADDR_BITS = 12,
  parameter int unsigned MAX_READ  = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  brb_stream_if.sink          in_i,
  brb_stream_if.source        out_o
);

  localparam int unsigned LW = brb_pkg::LEN_W;
  localparam int unsigned CW = (ADDR_BITS > LW) ? ADDR_BITS : LW;
  localparam int unsigned NW = $clog2(MAX_READ + 1);

  typedef enum logic {
    S_IDLE,
    S_PEEK
  } state_e;

  state_e               state_q, state_d;
  logic [ADDR_BITS-1:0] rptr_q, rptr_d;
  logic [ADDR_BITS-1:0] wptr_q, wptr_d;
  logic [ADDR_BITS-1:0] held_q, held_d;
  logic                 bact_q, bact_d;
  logic                 brej_q, brej_d;
  logic [LW-1:0]        bcnt_q, bcnt_d;
  logic [NW-1:0]        pk_n_q, pk_n_d;
  logic [NW-1:0]        pk_idx_q, pk_idx_d;
  logic                 out_valid_q, out_valid_d;
  brb_pkg::out_t        out_q, out_d;

  // Store ports
  logic                 wr_en;
  logic [ADDR_BITS-1:0] wr_addr;
  logic                 rd_en;
  logic [ADDR_BITS-1:0] rd_addr;
  logic [7:0]           rd_data;

  // Decode helpers
  logic                 in_acc;
  logic                 slot_free;
  logic [CW-1:0]        len_cw;
  logic [CW-1:0]        held_cw;
  logic [CW-1:0]        free_now_cw;
  logic [CW-1:0]        free_d_cw;
  logic [ADDR_BITS-1:0] len_a;
  logic                 wr_rej;
  logic [LW-1:0]        wr_bcnt;
  logic [LW-1:0]        bcnt_new;
  logic                 wr_store;
  logic [CW-1:0]        pk_n_cw;
  logic [NW-1:0]        pk_n;
  logic [NW-1:0]        pk_idx_nx;
  logic                 cons_over;

  brb_mem #(
    .ADDR_BITS (ADDR_BITS)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (in_i.payload.data_byte),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Handshake
  assign slot_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE) && slot_free;
  assign in_acc = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.payload = out_q;

  // Operand widths
  assign len_cw      = CW'(in_i.payload.length);
  assign held_cw     = CW'(held_q);
  assign free_now_cw = CW'(~held_q);
  assign len_a       = len_cw[ADDR_BITS-1:0];

  // Burst decision is latched on its first byte
  assign wr_rej   = bact_q ? brej_q : (len_cw > free_now_cw);
  assign wr_bcnt  = bact_q ? bcnt_q : '0;
  assign wr_store = !wr_rej && (wr_bcnt < in_i.payload.length) && (held_q != '1);
  assign bcnt_new = wr_store ? wr_bcnt + 1'b1 : wr_bcnt;

  // Peek size: min(length, MAX_READ, held)
  always_comb begin
    pk_n_cw = len_cw;
    if (pk_n_cw > CW'(MAX_READ)) begin
      pk_n_cw = CW'(MAX_READ);
    end
    if (pk_n_cw > held_cw) begin
      pk_n_cw = held_cw;
    end
  end
  assign pk_n      = pk_n_cw[NW-1:0];
  assign pk_idx_nx = pk_idx_q + 1'b1;

  assign cons_over = len_cw > held_cw;

  // Next-state logic
  always_comb begin
    state_d     = state_q;
    rptr_d      = rptr_q;
    wptr_d      = wptr_q;
    held_d      = held_q;
    bact_d      = bact_q;
    brej_d      = brej_q;
    bcnt_d      = bcnt_q;
    pk_n_d      = pk_n_q;
    pk_idx_d    = pk_idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;
    wr_en       = 1'b0;
    wr_addr     = wptr_q;
    rd_en       = 1'b0;
    rd_addr     = rptr_q;
    free_d_cw   = '0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_i.payload.func)
            brb_pkg::FUNC_WRITE: begin
              if (wr_store) begin
                wr_en  = 1'b1;
                wptr_d = wptr_q + 1'b1;
                held_d = held_q + 1'b1;
              end
              if (in_i.payload.last_byte) begin
                out_valid_d         = 1'b1;
                out_d.out_byte      = '0;
                out_d.count         = wr_rej ? '0 : bcnt_new;
                out_d.status        = wr_rej ? brb_pkg::ST_NO_ROOM : brb_pkg::ST_OK;
                out_d.last_result   = 1'b1;
                bact_d = 1'b0;
                brej_d = 1'b0;
                bcnt_d = '0;
              end else begin
                bact_d = 1'b1;
                brej_d = wr_rej;
                bcnt_d = bcnt_new;
              end
            end
            brb_pkg::FUNC_PEEK: begin
              if (pk_n == '0) begin
                out_valid_d       = 1'b1;
                out_d.out_byte    = '0;
                out_d.count       = '0;
                out_d.status      = brb_pkg::ST_OK;
                out_d.last_result = 1'b1;
              end else begin
                rd_en    = 1'b1;
                rd_addr  = rptr_q;
                pk_n_d   = pk_n;
                pk_idx_d = '0;
                state_d  = S_PEEK;
              end
            end
            brb_pkg::FUNC_CONSUME: begin
              out_valid_d       = 1'b1;
              out_d.out_byte    = '0;
              out_d.last_result = 1'b1;
              if (cons_over) begin
                out_d.count  = '0;
                out_d.status = brb_pkg::ST_OVER;
              end else begin
                out_d.count  = in_i.payload.length;
                out_d.status = brb_pkg::ST_OK;
                held_d       = held_q - len_a;
                // Emptied: both pointers go home
                if (held_q == len_a) begin
                  rptr_d = '0;
                  wptr_d = '0;
                end else begin
                  rptr_d = rptr_q + len_a;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_PEEK: begin
        // When the output slot is free, emit the fetched byte and, unless it is the last, fetch the next one
        if (slot_free) begin
          out_valid_d       = 1'b1;
          out_d.out_byte    = rd_data;
          out_d.count       = LW'(pk_n_q);
          out_d.status      = brb_pkg::ST_OK;
          out_d.last_result = (pk_idx_nx == pk_n_q);
          pk_idx_d          = pk_idx_nx;
          if (pk_idx_nx == pk_n_q) begin
            state_d = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = rptr_q + ADDR_BITS'(pk_idx_nx);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Free space reported after the operation
    free_d_cw = CW'(~held_d);
    if (out_valid_d && !(out_valid_q && !out_o.ready)) begin
      out_d.free_space = free_d_cw[LW-1:0];
    end
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rptr_q      <= '0;
      wptr_q      <= '0;
      held_q      <= '0;
      bact_q      <= 1'b0;
      brej_q      <= 1'b0;
      bcnt_q      <= '0;
      pk_n_q      <= '0;
      pk_idx_q    <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      rptr_q      <= rptr_d;
      wptr_q      <= wptr_d;
      held_q      <= held_d;
      bact_q      <= bact_d;
      brej_q      <= brej_d;
      bcnt_q      <= bcnt_d;
      pk_n_q      <= pk_n_d;
      pk_idx_q    <= pk_idx_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  // Pointer distance always equals the held count
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ADDR_BITS'(wptr_q - rptr_q) == held_q)
    else $error("pointer distance differs from held count");

  // Error results never report a count
  a_err_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != brb_pkg::ST_OK) |-> (out_q.count == '0))
    else $error("error result with nonzero count");

  // A running peek stays inside the held bytes
  a_peek_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PEEK) |-> ((pk_idx_q < pk_n_q) && (CW'(pk_n_q) <= held_cw)))
    else $error("peek index out of range");

endmodule

>>> verif/byte_ring_buffer_peek_consume_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_ring_buffer_peek_consume_test
// Self-checking bench for the byte ring buffer. Write bursts, peeks and
// consumes are driven over the command channel with random gaps. A behavioral
// ring model predicts every result word, and each returned word is compared
// field by field, in order. The run covers a back-to-back stretch with a
// burst length that changes mid-burst, and a long output stall that backs up
// the command channel.
// ----------------------------------------------------------------------------
module byte_ring_buffer_peek_consume_test;

  localparam int unsigned ADDR_BITS  = 12;
  localparam int unsigned MAX_READ   = 64;
  localparam int unsigned RING_DEPTH = 1 << ADDR_BITS;
  localparam int unsigned FULL_HELD  = RING_DEPTH - 1;
  localparam int unsigned LEN_MAX    = (1 << brb_pkg::LEN_W) - 1;

  // func code the block ignores
  localparam logic [brb_pkg::FUNC_W-1:0] FUNC_NONE = 2'd3;

  // Behavioral ring: tracks buffer state and queues the expected result words
  class ring_model;
    logic [brb_pkg::BYTE_W-1:0] mem [RING_DEPTH];
    int unsigned   rd_ptr, wr_ptr, held, burst_cnt;
    bit            in_burst, burst_drop;
    brb_pkg::out_t pending[$];
    int unsigned   mismatches;

    function int unsigned room();
      return FULL_HELD - held;
    endfunction

    function void push_result(logic [brb_pkg::BYTE_W-1:0] b, int unsigned cnt,
                              logic [brb_pkg::ST_W-1:0] st, logic last);
      brb_pkg::out_t r;
      r.out_byte    = b;
      r.count       = brb_pkg::LEN_W'(cnt);
      r.status      = st;
      r.free_space  = brb_pkg::LEN_W'(room());
      r.last_result = last;
      pending.push_back(r);
    endfunction

    // Apply one accepted command word
    function void take_command(brb_pkg::in_t c);
      int unsigned n;
      case (c.func)
        brb_pkg::FUNC_WRITE: begin
          // accept/reject is latched on the first byte of a burst
          if (!in_burst) begin
            in_burst   = 1'b1;
            burst_cnt  = 0;
            burst_drop = (c.length > room());
          end
          if (!burst_drop && burst_cnt < c.length && held < FULL_HELD) begin
            mem[wr_ptr] = c.data_byte;
            wr_ptr      = (wr_ptr + 1) % RING_DEPTH;
            held++;
            burst_cnt++;
          end
          if (c.last_byte) begin
            if (burst_drop) push_result('0, 0, brb_pkg::ST_NO_ROOM, 1'b1);
            else            push_result('0, burst_cnt, brb_pkg::ST_OK, 1'b1);
            in_burst   = 1'b0;
            burst_drop = 1'b0;
            burst_cnt  = 0;
          end
        end
        brb_pkg::FUNC_PEEK: begin
          n = c.length;
          if (n > MAX_READ) n = MAX_READ;
          if (n > held)     n = held;
          if (n == 0) begin
            push_result('0, 0, brb_pkg::ST_OK, 1'b1);
          end else begin
            for (int unsigned i = 0; i < n; i++)
              push_result(mem[(rd_ptr + i) % RING_DEPTH], n, brb_pkg::ST_OK, i + 1 == n);
          end
        end
        brb_pkg::FUNC_CONSUME: begin
          if (c.length > held) begin
            push_result('0, 0, brb_pkg::ST_OVER, 1'b1);
          end else begin
            rd_ptr = (rd_ptr + c.length) % RING_DEPTH;
            held   = held - c.length;
            // empty buffer rewinds both pointers
            if (held == 0) begin
              rd_ptr = 0;
              wr_ptr = 0;
            end
            push_result('0, c.length, brb_pkg::ST_OK, 1'b1);
          end
        end
        default: ;
      endcase
    endfunction

    function void flag(string field, int unsigned want, int unsigned got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    endfunction

    // Compare one returned word with the oldest expectation
    function void match_result(brb_pkg::out_t got);
      brb_pkg::out_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (got.out_byte !== want.out_byte)
        flag("out_byte", want.out_byte, got.out_byte);
      if (got.count !== want.count)
        flag("count", want.count, got.count);
      if (got.status !== want.status)
        flag("status", want.status, got.status);
      if (got.free_space !== want.free_space)
        flag("free_space", want.free_space, got.free_space);
      if (got.last_result !== want.last_result)
        flag("last_result", want.last_result, got.last_result);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  brb_stream_if #(.payload_t(brb_pkg::in_t))  cmd_if ();
  brb_stream_if #(.payload_t(brb_pkg::out_t)) res_if ();

  byte_ring_buffer_peek_consume #(
    .ADDR_BITS (ADDR_BITS),
    .MAX_READ  (MAX_READ)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  ring_model   ring = new();
  int unsigned items_sent = 0;
  bit          steady_tx = 1'b0;
  bit          steady_rx = 1'b0;
  bit          squeeze_req = 1'b0;

  always #2 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55)      return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else             return $urandom_range(20, 60);
  endfunction

  function automatic brb_pkg::in_t mk(logic [brb_pkg::FUNC_W-1:0] f,
                                      logic [brb_pkg::BYTE_W-1:0] d,
                                      logic [brb_pkg::LEN_W-1:0] len, logic last);
    brb_pkg::in_t w;
    w.func      = f;
    w.data_byte = d;
    w.length    = len;
    w.last_byte = last;
    return w;
  endfunction

  function automatic logic [brb_pkg::BYTE_W-1:0] rand_byte();
    return brb_pkg::BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [brb_pkg::LEN_W-1:0] peek_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70)      return brb_pkg::LEN_W'($urandom_range(0, 72));
    else if (r < 85) return brb_pkg::LEN_W'($urandom_range(60, 70));
    else             return brb_pkg::LEN_W'($urandom_range(0, LEN_MAX));
  endfunction

  function automatic logic [brb_pkg::LEN_W-1:0] consume_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75)      return brb_pkg::LEN_W'($urandom_range(0, ring.held / 3));
    else if (r < 85) return brb_pkg::LEN_W'(ring.held);
    else if (r < 95) return brb_pkg::LEN_W'(ring.held + $urandom_range(1, 10));
    else             return brb_pkg::LEN_W'($urandom_range(0, LEN_MAX));
  endfunction

  // Offer one word; starts and returns at a falling edge
  task automatic send_word(input brb_pkg::in_t w);
    int unsigned gap;
    gap = steady_tx ? 0 : idle_len();
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.payload <= w;
    do @(posedge clk_i); while (!cmd_if.ready);
    ring.take_command(w);
    if (w.func != FUNC_NONE) items_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_burst(input int unsigned len, input int unsigned nbytes);
    for (int unsigned i = 0; i < nbytes; i++)
      send_word(mk(brb_pkg::FUNC_WRITE, rand_byte(), brb_pkg::LEN_W'(len),
                   i + 1 == nbytes));
  endtask

  // Extremes and corner cases, one at a time
  task automatic directed_cases();
    send_word(mk(brb_pkg::FUNC_PEEK, 8'h00, 12'd0, 1'b0));     // peek on empty buffer
    send_word(mk(brb_pkg::FUNC_CONSUME, 8'h00, 12'd0, 1'b0));  // consume nothing
    send_word(mk(brb_pkg::FUNC_CONSUME, 8'h00, 12'd1, 1'b0));  // consume beyond held
    send_word(mk(FUNC_NONE, 8'hff, 12'hfff, 1'b1));            // ignored func
    // zero-length burst: accepted, nothing stored
    send_word(mk(brb_pkg::FUNC_WRITE, 8'h11, 12'd0, 1'b0));
    send_word(mk(brb_pkg::FUNC_WRITE, 8'h22, 12'd0, 1'b1));
    // largest length still fits an empty buffer
    send_word(mk(brb_pkg::FUNC_WRITE, 8'h00, 12'hfff, 1'b0));
    send_word(mk(brb_pkg::FUNC_WRITE, 8'hff, 12'hfff, 1'b0));
    send_word(mk(brb_pkg::FUNC_WRITE, 8'ha5, 12'hfff, 1'b1));
    send_word(mk(brb_pkg::FUNC_PEEK, 8'h00, 12'hfff, 1'b0));   // clipped to held
    // excess bytes past the burst length are dropped
    send_word(mk(brb_pkg::FUNC_WRITE, 8'h5a, 12'd2, 1'b0));
    send_word(mk(brb_pkg::FUNC_WRITE, 8'hc3, 12'd2, 1'b0));
    send_word(mk(brb_pkg::FUNC_WRITE, 8'h0f, 12'd2, 1'b0));
    send_word(mk(brb_pkg::FUNC_WRITE, 8'hf0, 12'd2, 1'b1));
    // one more than the free space: rejected whole
    send_word(mk(brb_pkg::FUNC_WRITE, 8'h33, brb_pkg::LEN_W'(ring.room() + 1), 1'b0));
    send_word(mk(brb_pkg::FUNC_WRITE, 8'h44, brb_pkg::LEN_W'(ring.room() + 1), 1'b1));
    send_word(mk(brb_pkg::FUNC_PEEK, 8'h00, 12'd1, 1'b1));
    // peek and consume in the middle of a burst
    send_word(mk(brb_pkg::FUNC_WRITE, 8'h81, 12'd3, 1'b0));
    send_word(mk(brb_pkg::FUNC_PEEK, 8'h00, 12'd8, 1'b0));
    send_word(mk(brb_pkg::FUNC_CONSUME, 8'h00, 12'd1, 1'b0));
    send_word(mk(brb_pkg::FUNC_WRITE, 8'h7e, 12'd3, 1'b0));
    send_word(mk(brb_pkg::FUNC_WRITE, 8'h18, 12'd3, 1'b1));
    send_word(mk(brb_pkg::FUNC_CONSUME, 8'h00, 12'hfff, 1'b0));
    // drains it
    send_word(mk(brb_pkg::FUNC_CONSUME, 8'h00, brb_pkg::LEN_W'(ring.held), 1'b0));
  endtask

  // Back-to-back words with no stalls on either side
  task automatic steady_run();
    steady_tx = 1'b1;
    steady_rx = 1'b1;
    write_burst(5, 5);
    send_word(mk(brb_pkg::FUNC_CONSUME, 8'h00, 12'd3, 1'b0));
    // small length on the first byte sets the decision; a larger length
    // on later bytes lets more of them in, the rest run past it
    send_word(mk(brb_pkg::FUNC_WRITE, rand_byte(), 12'd1, 1'b0));
    for (int unsigned i = 1; i < 6; i++)
      send_word(mk(brb_pkg::FUNC_WRITE, rand_byte(), 12'd4, i == 5));
    send_word(mk(brb_pkg::FUNC_PEEK, 8'h00, 12'hfff, 1'b0));
    write_burst(LEN_MAX, 1);                             // no room: rejected
    send_word(mk(brb_pkg::FUNC_CONSUME, 8'h00, 12'd4, 1'b0));
    send_word(mk(brb_pkg::FUNC_PEEK, 8'h00, 12'd8, 1'b0));
    send_word(mk(brb_pkg::FUNC_CONSUME, 8'h00, brb_pkg::LEN_W'(ring.held), 1'b0));
    steady_tx = 1'b0;
    steady_rx = 1'b0;
  endtask

  // Mostly well-formed bursts with random content; some broken shapes
  task automatic random_burst();
    int unsigned r, len, nbytes;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      len    = $urandom_range(1, 12);
      nbytes = len;
    end else if (r < 70) begin
      len    = $urandom_range(1, 6);
      nbytes = len + $urandom_range(1, 3);
    end else if (r < 78) begin
      len    = $urandom_range(4, 20);
      nbytes = $urandom_range(1, len);
    end else if (r < 88) begin
      len    = ring.room() + $urandom_range(1, 40);
      if (len > LEN_MAX) len = LEN_MAX;
      nbytes = $urandom_range(1, 4);
    end else if (r < 93) begin
      len    = 0;
      nbytes = $urandom_range(1, 3);
    end else begin
      len    = $urandom_range(0, LEN_MAX);
      nbytes = $urandom_range(1, 8);
    end
    for (int unsigned i = 0; i < nbytes; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        if ($urandom_range(0, 1) == 0)
          send_word(mk(brb_pkg::FUNC_PEEK, rand_byte(), peek_len(),
                       1'($urandom_range(0, 1))));
        else
          send_word(mk(brb_pkg::FUNC_CONSUME, rand_byte(), consume_len(),
                       1'($urandom_range(0, 1))));
      end
      if ($urandom_range(0, 24) == 0) len = $urandom_range(0, LEN_MAX);
      send_word(mk(brb_pkg::FUNC_WRITE, rand_byte(), brb_pkg::LEN_W'(len),
                   i + 1 == nbytes));
    end
  endtask

  task automatic random_traffic(input int unsigned quota);
    int unsigned start, pick;
    bit          squeezed;
    start    = items_sent;
    squeezed = 1'b0;
    while (items_sent - start < quota) begin
      // one long output stall while commands keep coming
      if (!squeezed && items_sent - start >= 100) begin
        squeeze_req = 1'b1;
        steady_tx   = 1'b1;
        squeezed    = 1'b1;
      end
      if ($urandom_range(0, 29) == 0) begin
        steady_tx = ($urandom_range(0, 2) == 0);
        steady_rx = ($urandom_range(0, 2) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 45)
        random_burst();
      else if (pick < 75)
        send_word(mk(brb_pkg::FUNC_PEEK, rand_byte(), peek_len(),
                     1'($urandom_range(0, 1))));
      else if (pick < 95)
        send_word(mk(brb_pkg::FUNC_CONSUME, rand_byte(), consume_len(),
                     1'($urandom_range(0, 1))));
      else
        send_word(mk(FUNC_NONE, rand_byte(), brb_pkg::LEN_W'($urandom_range(0, LEN_MAX)),
                     1'($urandom_range(0, 1))));
    end
  endtask

  // Result side: random back-pressure, checks each word taken
  initial begin : result_sink
    int unsigned hold;
    hold = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        hold        = 300;
      end
      res_if.ready <= (hold == 0);
      if (hold > 0) hold--;
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        ring.match_result(res_if.payload);
        hold = steady_rx ? 0 : idle_len();
      end
    end
  end

  // Command side and end of run
  initial begin : stimulus
    cmd_if.valid   = 1'b0;
    cmd_if.payload = '0;
    rst_ni         = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    directed_cases();
    steady_run();
    random_traffic(230);
    cmd_if.valid <= 1'b0;
    steady_rx = 1'b1;
    while (ring.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (ring.mismatches == 0 && ring.pending.size() == 0) begin
      $display("byte_ring_buffer_peek_consume_test: clean");
    end else begin
      $display("byte_ring_buffer_peek_consume_test: errors");
    end
    $finish;
  end

  // Hang guard
  initial begin : watchdog
    #30_000_000;
    $display("%0t: timeout, %0d result words still expected", $time, ring.pending.size());
    $display("byte_ring_buffer_peek_consume_test: errors");
    $finish;
  end

endmodule
